// File: design/rpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared widths and pipeline types for the vector reflect/project unit.
// ----------------------------------------------------------------------------
package rpu_pkg;

  localparam int CW = 32;           // component width, Q16.16
  localparam int DW = 64;           // d.d and |v.d| width
  localparam int NW = 96;           // |d_i| * |v.d| width
  localparam int QW = 33;           // quotient bits (|p| stays below 2^33)
  localparam int PW = 35;           // signed projection component
  localparam int RW = 36;           // signed raw result before clamping

  localparam logic [1:0] OP_REMOVE  = 2'd0;
  localparam logic [1:0] OP_REFLECT = 2'd1;
  localparam logic [1:0] OP_PROJECT = 2'd2;

  localparam logic signed [RW-1:0] SAT_MAX = RW'(64'sd2147483647);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(-64'sd2147483648);

  // per-request data that rides along with the divider
  typedef struct packed {
    logic [1:0]          op;
    logic [2:0][CW-1:0]  vec;
    logic                zero;
    logic [2:0]          pneg;
  } side_t;

  // one divider stage word, three lanes
  typedef struct packed {
    logic [2:0][DW-1:0]  rem;
    logic [2:0][QW-1:0]  quo;
    logic [2:0][NW-1:0]  num;
    logic [DW-1:0]       dd;
    side_t               side;
  } dv_t;

endpackage : rpu_pkg
`default_nettype wire

// File: design/rpu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_front
// Six stages: magnitudes, products, dot and d.d sums, sign split, numerator
// partial products, numerator sum and divider seed.
// ----------------------------------------------------------------------------
module rpu_front
  import rpu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [1:0]            in_op,
  input  wire logic signed [CW-1:0]  in_vec_x,
  input  wire logic signed [CW-1:0]  in_vec_y,
  input  wire logic signed [CW-1:0]  in_vec_z,
  input  wire logic signed [CW-1:0]  in_dir_x,
  input  wire logic signed [CW-1:0]  in_dir_y,
  input  wire logic signed [CW-1:0]  in_dir_z,
  output logic                       dv_valid,
  output dv_t                        dv
);

  logic [2:0][CW-1:0] vin, din;
  assign vin = {in_vec_z, in_vec_y, in_vec_x};
  assign din = {in_dir_z, in_dir_y, in_dir_x};

  // stage 1: magnitudes and signs
  logic s1_vld_r;
  logic [1:0] s1_op_r;
  logic [2:0][CW-1:0] s1_vec_r, s1_vm_r, s1_dm_r;
  logic [2:0] s1_vn_r, s1_dn_r;

  // stage 2: products
  logic s2_vld_r;
  logic [1:0] s2_op_r;
  logic [2:0][CW-1:0] s2_vec_r, s2_dm_r;
  logic [2:0][DW-1:0] s2_pvd_r, s2_pdd_r;
  logic [2:0] s2_pn_r, s2_dn_r;

  // stage 3: sums
  logic s3_vld_r;
  logic [1:0] s3_op_r;
  logic [2:0][CW-1:0] s3_vec_r, s3_dm_r;
  logic [2:0] s3_dn_r;
  logic signed [DW+1:0] s3_dot_r, s3_dot_nxt;
  logic [DW-1:0] s3_dd_r, s3_dd_nxt;

  // stage 4: dot magnitude
  logic s4_vld_r;
  logic [1:0] s4_op_r;
  logic [2:0][CW-1:0] s4_vec_r, s4_dm_r;
  logic [2:0] s4_dn_r;
  logic [DW-1:0] s4_dmag_r, s4_dd_r;
  logic s4_dneg_r, s4_zero_r;

  // stage 5: numerator halves
  logic s5_vld_r;
  logic [DW-1:0] s5_dd_r;
  side_t s5_side_r;
  logic [2:0][DW-1:0] s5_m0_r, s5_m1_r;

  // stage 6: divider seed
  dv_t s6_r, s6_nxt;
  logic s6_vld_r;

  always_comb begin
    logic signed [DW+1:0] term;
    s3_dot_nxt = '0;
    s3_dd_nxt  = '0;
    for (int l = 0; l < 3; l++) begin
      term = $signed({2'b00, s2_pvd_r[l]});
      s3_dot_nxt = s2_pn_r[l] ? s3_dot_nxt - term : s3_dot_nxt + term;
      s3_dd_nxt  = s3_dd_nxt + s2_pdd_r[l];
    end
  end

  always_comb begin
    logic [NW-1:0] num;
    s6_nxt = '0;
    s6_nxt.dd   = s5_dd_r;
    s6_nxt.side = s5_side_r;
    for (int l = 0; l < 3; l++) begin
      num = {32'd0, s5_m0_r[l]} + {s5_m1_r[l], 32'd0};
      s6_nxt.num[l] = num;
      // quotient < 2^QW, so the top bits are already below d.d
      s6_nxt.rem[l] = DW'(num[NW-1:QW]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r  <= in_op;
      s1_vec_r <= vin;
      for (int l = 0; l < 3; l++) begin
        s1_vn_r[l] <= vin[l][CW-1];
        s1_dn_r[l] <= din[l][CW-1];
        s1_vm_r[l] <= vin[l][CW-1] ? CW'(-vin[l]) : vin[l];
        s1_dm_r[l] <= din[l][CW-1] ? CW'(-din[l]) : din[l];
      end

      s2_op_r  <= s1_op_r;
      s2_vec_r <= s1_vec_r;
      s2_dm_r  <= s1_dm_r;
      s2_dn_r  <= s1_dn_r;
      for (int l = 0; l < 3; l++) begin
        s2_pvd_r[l] <= s1_vm_r[l] * s1_dm_r[l];
        s2_pdd_r[l] <= s1_dm_r[l] * s1_dm_r[l];
        s2_pn_r[l]  <= s1_vn_r[l] ^ s1_dn_r[l];
      end

      s3_op_r  <= s2_op_r;
      s3_vec_r <= s2_vec_r;
      s3_dm_r  <= s2_dm_r;
      s3_dn_r  <= s2_dn_r;
      s3_dot_r <= s3_dot_nxt;
      s3_dd_r  <= s3_dd_nxt;

      s4_op_r   <= s3_op_r;
      s4_vec_r  <= s3_vec_r;
      s4_dm_r   <= s3_dm_r;
      s4_dn_r   <= s3_dn_r;
      s4_dneg_r <= s3_dot_r[DW+1];
      s4_dmag_r <= s3_dot_r[DW+1] ? DW'(-s3_dot_r) : DW'(s3_dot_r);
      s4_dd_r   <= s3_dd_r;
      s4_zero_r <= (s3_dd_r == '0);

      s5_dd_r        <= s4_dd_r;
      s5_side_r.op   <= s4_op_r;
      s5_side_r.vec  <= s4_vec_r;
      s5_side_r.zero <= s4_zero_r;
      for (int l = 0; l < 3; l++) begin
        s5_side_r.pneg[l] <= s4_dn_r[l] ^ s4_dneg_r;
        s5_m0_r[l] <= s4_dm_r[l] * s4_dmag_r[31:0];
        s5_m1_r[l] <= s4_dm_r[l] * s4_dmag_r[63:32];
      end

      s6_r <= s6_nxt;
    end
  end

  assign dv_valid = s6_vld_r;
  assign dv       = s6_r;

endmodule : rpu_front
`default_nettype wire

// File: design/rpu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_div
// Restoring divider, one quotient bit per stage, three lanes side by side.
// ----------------------------------------------------------------------------
module rpu_div
  import rpu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  dv_t        in_dv,
  output logic       out_valid,
  output dv_t        out_dv
);

  dv_t  stg_in  [0:QW-1];
  logic stg_vld [0:QW-1];
  dv_t  pipe_r  [1:QW];
  logic vld_r   [1:QW];

  assign stg_in[0]  = in_dv;
  assign stg_vld[0] = in_valid;

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_stage
      dv_t stg_nxt;

      if (s > 0) begin : g_link
        assign stg_in[s]  = pipe_r[s];
        assign stg_vld[s] = vld_r[s];
      end

      // quotient bit QW-1-s
      always_comb begin
        logic [DW:0] trial;
        stg_nxt = stg_in[s];
        for (int l = 0; l < 3; l++) begin
          trial = {stg_in[s].rem[l], stg_in[s].num[l][QW-1-s]};
          if (trial >= {1'b0, stg_in[s].dd}) begin
            stg_nxt.rem[l] = DW'(trial - {1'b0, stg_in[s].dd});
            stg_nxt.quo[l] = {stg_in[s].quo[l][QW-2:0], 1'b1};
          end else begin
            stg_nxt.rem[l] = trial[DW-1:0];
            stg_nxt.quo[l] = {stg_in[s].quo[l][QW-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[s+1] <= stg_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s+1] <= 1'b0;
        end else if (en) begin
          vld_r[s+1] <= stg_vld[s];
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[QW];
  assign out_dv    = pipe_r[QW];

endmodule : rpu_div
`default_nettype wire

// File: design/rpu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_back
// Rounds the quotient into the signed projection, then forms the op result
// with saturation in the output register.
// ----------------------------------------------------------------------------
module rpu_back
  import rpu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  dv_t                        in_dv,
  output logic                       out_valid,
  output logic signed [CW-1:0]       out_res_x,
  output logic signed [CW-1:0]       out_res_y,
  output logic signed [CW-1:0]       out_res_z,
  output logic                       out_zero_direction,
  output logic                       out_clipped
);

  logic b1_vld_r;
  side_t b1_side_r;
  logic [2:0][PW-1:0] b1_p_r, b1_p_nxt;

  logic b2_vld_r;
  logic [2:0][CW-1:0] b2_res_r, b2_res_nxt;
  logic b2_zero_r, b2_clip_r, b2_clip_nxt;

  // round half away from zero, apply sign, force zero for a null direction
  always_comb begin
    logic        rnd;
    logic [QW:0] qr;
    for (int l = 0; l < 3; l++) begin
      rnd = ({in_dv.rem[l], 1'b0} >= {1'b0, in_dv.dd});
      qr  = {1'b0, in_dv.quo[l]} + (QW+1)'(rnd);
      if (in_dv.side.zero) begin
        b1_p_nxt[l] = '0;
      end else if (in_dv.side.pneg[l]) begin
        b1_p_nxt[l] = PW'(-{1'b0, qr});
      end else begin
        b1_p_nxt[l] = PW'({1'b0, qr});
      end
    end
  end

  // op select and clamp
  always_comb begin
    logic signed [RW-1:0] v, p, r;
    b2_clip_nxt = 1'b0;
    for (int l = 0; l < 3; l++) begin
      v = RW'($signed(b1_side_r.vec[l]));
      p = RW'($signed(b1_p_r[l]));
      case (b1_side_r.op)
        OP_REFLECT: r = v - (p <<< 1);
        OP_PROJECT: r = p;
        default:    r = v - p;
      endcase
      if (r > SAT_MAX) begin
        b2_res_nxt[l] = SAT_MAX[CW-1:0];
        b2_clip_nxt   = 1'b1;
      end else if (r < SAT_MIN) begin
        b2_res_nxt[l] = SAT_MIN[CW-1:0];
        b2_clip_nxt   = 1'b1;
      end else begin
        b2_res_nxt[l] = r[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
    end else if (en) begin
      b1_vld_r <= in_valid;
      b2_vld_r <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_side_r <= in_dv.side;
      b1_p_r    <= b1_p_nxt;
      b2_res_r  <= b2_res_nxt;
      b2_zero_r <= b1_side_r.zero;
      b2_clip_r <= b2_clip_nxt;
    end
  end

  assign out_valid          = b2_vld_r;
  assign out_res_x          = b2_res_r[0];
  assign out_res_y          = b2_res_r[1];
  assign out_res_z          = b2_res_r[2];
  assign out_zero_direction = b2_zero_r;
  assign out_clipped        = b2_clip_r;

endmodule : rpu_back
`default_nettype wire

// File: design/vector3_reflect_project_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_reflect_project_unit
// Removes, reflects or projects a Q16.16 vector against a direction.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is accepted per cycle unless the output
// stalls. Each result passes 6 front stages for magnitudes, products and
// the numerator, 33 divider stages at one quotient bit each and 2 back stages
// for rounding and saturation. The whole pipeline holds while a result sits
// unaccepted on the output; in_ready is low only then. A zero direction
// gives v for ops 0/1 (and op 3) and zero for op 2, with zero_direction set.
module vector3_reflect_project_unit
  import rpu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic signed [CW-1:0]  in_vec_x,
  input  wire logic signed [CW-1:0]  in_vec_y,
  input  wire logic signed [CW-1:0]  in_vec_z,
  input  wire logic signed [CW-1:0]  in_dir_x,
  input  wire logic signed [CW-1:0]  in_dir_y,
  input  wire logic signed [CW-1:0]  in_dir_z,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [CW-1:0]       out_res_x,
  output logic signed [CW-1:0]       out_res_y,
  output logic signed [CW-1:0]       out_res_z,
  output logic                       out_zero_direction,
  output logic                       out_clipped
);

  logic en;
  logic fr_valid, dv_valid;
  dv_t  fr_dv, dv_out;

  // global advance: hold everything while the output request is stalled
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  rpu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_vec_x (in_vec_x),
    .in_vec_y (in_vec_y),
    .in_vec_z (in_vec_z),
    .in_dir_x (in_dir_x),
    .in_dir_y (in_dir_y),
    .in_dir_z (in_dir_z),
    .dv_valid (fr_valid),
    .dv       (fr_dv)
  );

  rpu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_dv     (fr_dv),
    .out_valid (dv_valid),
    .out_dv    (dv_out)
  );

  rpu_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .in_valid           (dv_valid),
    .in_dv              (dv_out),
    .out_valid          (out_valid),
    .out_res_x          (out_res_x),
    .out_res_y          (out_res_y),
    .out_res_z          (out_res_z),
    .out_zero_direction (out_zero_direction),
    .out_clipped        (out_clipped)
  );

endmodule : vector3_reflect_project_unit
`default_nettype wire

// File: design/rpu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_checker
// Port-level checks for vector3_reflect_project_unit, bound to the top level.
// ----------------------------------------------------------------------------
module rpu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_res_x,
  input wire logic [31:0] out_res_y,
  input wire logic [31:0] out_res_z,
  input wire logic        out_zero_direction,
  input wire logic        out_clipped
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_x) &&
      $stable(out_res_y) && $stable(out_res_z) && $stable(out_clipped))
    else $error("stalled result changed");

  // input side only backs off behind an output stall
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a null direction never causes saturation
  a_zero_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_direction |-> !out_clipped)
    else $error("clipped with zero direction");

  // clipping shows a rail value somewhere
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_res_x == 32'h7fffffff || out_res_x == 32'h80000000 ||
      out_res_y == 32'h7fffffff || out_res_y == 32'h80000000 ||
      out_res_z == 32'h7fffffff || out_res_z == 32'h80000000)
    else $error("clipped without rail value");

  // pipeline empties on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule : rpu_checker

bind vector3_reflect_project_unit rpu_checker u_rpu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_res_x          (out_res_x),
  .out_res_y          (out_res_y),
  .out_res_z          (out_res_z),
  .out_zero_direction (out_zero_direction),
  .out_clipped        (out_clipped)
);
`default_nettype wire

// File: tb/vector3_reflect_project_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_reflect_project_unit_tb
// Drives remove/reflect/project requests through the unit with random idle on
// both channels and checks every result against an exact wide-integer model.
// ----------------------------------------------------------------------------
module vector3_reflect_project_unit_tb;
  import rpu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 300;
  localparam int DRAIN_WAIT  = 60;
  localparam logic [1:0] OP_SPARE = 2'd3;   // handled like remove

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] vec [3];
    logic signed [31:0] dir [3];
  } vreq_t;

  typedef struct {
    logic signed [31:0] res [3];
    logic               zero_dir;
    logic               clip;
  } vres_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic signed [CW-1:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic signed [CW-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_res_x, out_res_y, out_res_z;
  logic out_zero_direction, out_clipped;

  vreq_t pending_reqs [$];
  vres_t expected_res [$];
  vreq_t cur_req;
  int    send_idle = 0, recv_idle = 0;
  bit    sender_hold = 1'b0;
  bit    long_stall_req = 1'b0;
  bit    long_stall_done = 1'b0;
  int    stall_left = 0;
  int    mismatches = 0;
  int    cycles = 0;

  vector3_reflect_project_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_x(out_res_x), .out_res_y(out_res_y), .out_res_z(out_res_z),
    .out_zero_direction(out_zero_direction), .out_clipped(out_clipped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact projection p = d (v.d)/(d.d), rounded half away from zero
  function automatic vres_t reflect_project(vreq_t r);
    logic signed [127:0] v [3];
    logic signed [127:0] d [3];
    logic signed [127:0] dot, dd, num, q, rem, p, s;
    vres_t o;
    dot = 0;
    dd = 0;
    o.clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v[i] = r.vec[i];
      d[i] = r.dir[i];
      dot += v[i] * d[i];
      dd += d[i] * d[i];
    end
    o.zero_dir = (dd == 0);
    for (int i = 0; i < 3; i++) begin
      p = 0;
      if (dd != 0) begin
        num = (d[i] < 0 ? -d[i] : d[i]) * (dot < 0 ? -dot : dot);
        q = num / dd;
        rem = num % dd;
        if (rem >= dd - rem) q += 1;
        p = ((d[i] < 0) != (dot < 0)) ? -q : q;
      end
      case (r.op)
        OP_REFLECT: s = v[i] - 2 * p;
        OP_PROJECT: s = p;
        default:    s = v[i] - p;
      endcase
      if (s > 128'sd2147483647) begin
        s = 128'sd2147483647;
        o.clip = 1'b1;
      end else if (s < -128'sd2147483648) begin
        s = -128'sd2147483648;
        o.clip = 1'b1;
      end
      o.res[i] = s[31:0];
    end
    return o;
  endfunction

  // one component: full range, small, extreme or zero
  function automatic logic signed [31:0] rand_comp();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return $urandom;
      3, 4, 5: return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
      6:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      7:       return 0;
      default: return $signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000;
    endcase
  endfunction

  task automatic add_req(logic [1:0] op, logic signed [31:0] vx, vy, vz,
                         logic signed [31:0] dx, dy, dz);
    vreq_t r;
    r.op = op;
    r.vec[0] = vx; r.vec[1] = vy; r.vec[2] = vz;
    r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    vreq_t r;
    for (int k = 0; k < n; k++) begin
      r.op = ($urandom_range(0, 15) == 0) ? OP_SPARE : 2'($urandom_range(0, 2));
      for (int i = 0; i < 3; i++) r.vec[i] = rand_comp();
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < 3; i++) r.dir[i] = 0;
        1: begin
          for (int i = 0; i < 3; i++) r.dir[i] = 0;
          r.dir[$urandom_range(0, 2)] = rand_comp();
        end
        default: for (int i = 0; i < 3; i++) r.dir[i] = rand_comp();
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_res.push_back(reflect_project(cur_req));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && !sender_hold &&
            $urandom_range(0, 99) >= send_idle) begin
          cur_req = pending_reqs.pop_front();
          in_op    <= cur_req.op;
          in_vec_x <= cur_req.vec[0];
          in_vec_y <= cur_req.vec[1];
          in_vec_z <= cur_req.vec[2];
          in_dir_x <= cur_req.dir[0];
          in_dir_y <= cur_req.dir[1];
          in_dir_z <= cur_req.dir[2];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    vres_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%h y=%h z=%h", out_res_x, out_res_y, out_res_z);
      end else begin
        e = expected_res.pop_front();
        if (out_res_x !== e.res[0] || out_res_y !== e.res[1] || out_res_z !== e.res[2] ||
            out_zero_direction !== e.zero_dir || out_clipped !== e.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h z%b c%b, got %h %h %h z%b c%b",
                     e.res[0], e.res[1], e.res[2], e.zero_dir, e.clip,
                     out_res_x, out_res_y, out_res_z, out_zero_direction, out_clipped);
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done <= 1'b1;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every op, axis and zero directions, extremes, clipping
    for (int op = 0; op < 4; op++) begin
      add_req(2'(op), 32'sh0003_0000, -32'sh0002_8000, 32'sh0000_0001,
              0, 32'sh0001_0000, 0);
      add_req(2'(op), 32'sh1234_5678, -32'sh0765_4321, 32'sh7FFF_FFFF, 0, 0, 0);
    end
    add_req(OP_REFLECT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    add_req(OP_REFLECT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_req(OP_REMOVE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001);
    add_req(OP_PROJECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'sh0000_0001, 32'sh0000_0001, 32'sh8000_0000);
    add_req(OP_PROJECT, 32'sh0000_0001, 0, 0, 32'sh0000_0001, 32'sh0000_0001, 0);
    add_req(OP_PROJECT, 32'sh0000_0001, 0, 0, 32'sh0000_0002, 32'sh0000_0002, 0);
    add_req(OP_PROJECT, -32'sh0000_0001, 0, 0, 32'sh0000_0001, 32'sh0000_0001, 0);
    add_req(OP_REFLECT, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 32'sh7FFF_FFFF);
    add_req(OP_REMOVE, 0, 0, 0, 32'sh8000_0000, 0, 0);
    add_req(OP_SPARE, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
            32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    wait_drained();

    // random traffic with a sender that is rarely idle and a receiver that is often idle
    send_idle = 10;
    recv_idle = 65;
    add_random(210);
    wait_drained();

    // receiver holds off for a long stretch while requests keep coming
    send_idle = 65;
    recv_idle = 10;
    long_stall_req = 1'b1;
    add_random(210);
    wait_drained();

    // full rate, with a mid-stream pause until every result is back
    send_idle = 0;
    recv_idle = 0;
    add_random(210);
    repeat (100) @(posedge clk);
    sender_hold <= 1'b1;
    @(posedge clk);
    while (in_valid || expected_res.size() != 0)
      @(posedge clk);
    sender_hold <= 1'b0;
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
